// ===== rtl/ampd_pkg.sv =====
// ----------------------------------------------------------------------------
// ampd_pkg
// Shared widths, register codes and status types for the acceleration
// magnitude peak detector.
// ----------------------------------------------------------------------------
package ampd_pkg;

  // Default ring depth in samples.
  localparam int WINDOW_MAX_DEF = 64;

  // Field and state widths.
  localparam int ACC_W  = 16;  // one acceleration axis
  localparam int IDX_W  = 31;  // sample index
  localparam int SQ_W   = 32;  // sum of three squares
  localparam int MAG_W  = 16;  // integer magnitude
  localparam int SUM_W  = 22;  // running sum, wraps
  localparam int FRAC_W = 8;   // fraction bits of the average
  localparam int MEAN_W = 24;  // average in 16.8
  localparam int WLEN_W = 7;
  localparam int REFR_W = 15;
  localparam int THR_W  = 24;

  // Register port.
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_REFRACTORY = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD  = 2'd2;

  localparam logic [WLEN_W-1:0] WLEN_RST = 7'd16;

  // Status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ===== rtl/ampd_ram.sv =====
// ----------------------------------------------------------------------------
// ampd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ampd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ampd_isqrt.sv =====
// ----------------------------------------------------------------------------
// ampd_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ampd_isqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ampd_pkg::SQ_W-1:0]  radicand_i,
  output logic [ampd_pkg::MAG_W-1:0] root_o,
  output ampd_pkg::unit_sts_t        sts_o
);
  import ampd_pkg::*;

  logic [SQ_W-1:0] n_q, root_q, bit_q;
  logic [SQ_W-1:0] n_d, root_d;
  logic [SQ_W:0]   trial;
  logic            busy_q, done_q;

  // One step of the digit-by-digit root.
  always_comb begin
    trial  = {1'b0, root_q} + {1'b0, bit_q};
    n_d    = n_q;
    root_d = root_q >> 1;
    if ({1'b0, n_q} >= trial) begin
      n_d    = n_q - trial[SQ_W-1:0];
      root_d = (root_q >> 1) + bit_q;
    end
  end

  // Control: sixteen steps, then a done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && bit_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= radicand_i;
      root_q <= '0;
      bit_q  <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_q) begin
      n_q    <= n_d;
      root_q <= root_d;
      bit_q  <= bit_q >> 2;
    end
  end

  assign root_o     = root_q[MAG_W-1:0];
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ===== rtl/ampd_div.sv =====
// ----------------------------------------------------------------------------
// ampd_div
// Iterative restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module ampd_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [DEN_W-1:0]   den_i,
  output logic [NUM_W-1:0]   quo_o,
  output ampd_pkg::unit_sts_t sts_o
);
  import ampd_pkg::*;

  localparam int CYC   = (NUM_W + 1) / 2;
  localparam int PAD_W = 2 * CYC;
  localparam int CNT_W = $clog2(CYC + 1);

  logic [PAD_W-1:0] num_q, quo_q, num_d, quo_d;
  logic [DEN_W:0]   rem_q, rem_d, trial;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  // Two dependent shift-and-subtract steps.
  always_comb begin
    rem_d = rem_q;
    num_d = num_q;
    quo_d = quo_q;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_d[DEN_W-1:0], num_d[PAD_W-1]};
      num_d = num_d << 1;
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
        quo_d = {quo_d[PAD_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[PAD_W-2:0], 1'b0};
      end
      rem_d = trial;
    end
  end

  // Control: count down the cycles.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(CYC);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= PAD_W'(num_i);
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o      = quo_q[NUM_W-1:0];
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ===== rtl/accel_magnitude_peak_detector.sv =====
// ----------------------------------------------------------------------------
// accel_magnitude_peak_detector
// Moving-average peak detector on the magnitude of three-axis samples.
// ----------------------------------------------------------------------------
// One sample is in flight at a time. The three axes are squared in turn on
// one 16x16 multiplier, and the ring memory is read with the first square.
// The bit-serial square root follows. The sum state updates the running sum
// and starts the divider, which forms the average two quotient bits a cycle.
// The done state commits, and the result register holds the beat. Most of
// a sample's time goes to the iterative root and divider. A new sample is
// taken as soon as the previous one commits. A stalled result beat delays
// the commit of the next sample, not its acceptance.
// Each sample yields exactly one result beat; peak_value is zero when
// peak_found is low.
// The magnitude ring lives in a RAM that is not cleared; sample index zero
// restarts averaging and detection.
module accel_magnitude_peak_detector #(
  parameter int WINDOW_MAX = ampd_pkg::WINDOW_MAX_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ampd_pkg::ADDR_W-1:0]     paddr,
  input  logic [ampd_pkg::DATA_W-1:0]     pwdata,
  output logic [ampd_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  // Sample channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [ampd_pkg::ACC_W-1:0] accel_x_i,
  input  logic signed [ampd_pkg::ACC_W-1:0] accel_y_i,
  input  logic signed [ampd_pkg::ACC_W-1:0] accel_z_i,
  input  logic [ampd_pkg::IDX_W-1:0]      sample_index_i,
  // Result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            peak_found_o,
  output logic [ampd_pkg::MEAN_W-1:0]     peak_value_o
);
  import ampd_pkg::*;

  localparam int POS_W = $clog2(WINDOW_MAX);
  localparam int DV_W  = $clog2(WINDOW_MAX + 1);
  localparam int NUM_W = SUM_W + FRAC_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQR  = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // Configuration registers.
  logic [WLEN_W-1:0] wlen_q;
  logic [REFR_W-1:0] refr_q;
  logic [THR_W-1:0]  thr_q;
  logic              cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;

  // Control and state.
  logic [2:0]       state_q, state_d;
  logic [1:0]       axis_q;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [POS_W-1:0] pos_q, slot_q, slot_d, slot_next;
  logic [MEAN_W-1:0] prev_mean_q;
  logic             prev_rising_q;
  logic [IDX_W-1:0] last_peak_q;
  logic             out_valid_q, peak_found_q;
  logic [MEAN_W-1:0] peak_value_q;

  // Sample registers.
  logic [ACC_W-1:0] ax_q, ay_q, az_q, axis_abs;
  logic [IDX_W-1:0] k_q;
  logic [SQ_W-1:0]  acc_q, sq_prod, sq_total;

  // Window, divisor and peak logic.
  logic [31:0]      wlen_ext;
  logic [DV_W-1:0]  weff, div_d;
  logic             warm;
  logic             accept_in, commit;
  logic [MAG_W-1:0] mag, ring_rdata;
  logic [NUM_W-1:0] quo;
  logic [MEAN_W-1:0] mean;
  logic             rising, peak;
  logic [IDX_W:0]   refr_limit;
  unit_sts_t        sq_sts, dv_sts;

  // Register writes and reads.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WLEN_RST;
      refr_q <= '0;
      thr_q  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WINDOW:     wlen_q <= pwdata[WLEN_W-1:0];
        REG_REFRACTORY: refr_q <= pwdata[REFR_W-1:0];
        REG_THRESHOLD:  thr_q  <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WINDOW:     prdata = DATA_W'(wlen_q);
      REG_REFRACTORY: prdata = DATA_W'(refr_q);
      REG_THRESHOLD:  prdata = DATA_W'(thr_q);
      default:        prdata = '0;
    endcase
  end

  // Effective window: zero acts as one, clamped to the ring depth.
  always_comb begin
    wlen_ext = 32'(wlen_q);
    if (wlen_ext == 32'd0) begin
      weff = DV_W'(1);
    end else if (wlen_ext > 32'(WINDOW_MAX)) begin
      weff = DV_W'(WINDOW_MAX);
    end else begin
      weff = DV_W'(wlen_ext);
    end
  end

  // Handshakes.
  assign accept_in  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign commit     = (state_q == S_DONE) && !(out_valid_q && out_stall_i);

  // Ring slot for a new sample: restart at zero, wrap if past the window.
  always_comb begin
    if (sample_index_i == '0 || DV_W'(pos_q) >= weff) begin
      slot_d = '0;
    end else begin
      slot_d = pos_q;
    end
  end

  assign slot_next = (DV_W'(slot_q) + DV_W'(1) >= weff) ? '0 : slot_q + POS_W'(1);

  // Squares of the three axes, one per cycle.
  always_comb begin
    case (axis_q)
      2'd0:    axis_abs = ax_q;
      2'd1:    axis_abs = ay_q;
      default: axis_abs = az_q;
    endcase
  end

  assign sq_prod  = SQ_W'(axis_abs) * SQ_W'(axis_abs);
  assign sq_total = acc_q + sq_prod;

  ampd_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_SQR && axis_q == 2'd2),
    .radicand_i (sq_total),
    .root_o     (mag),
    .sts_o      (sq_sts)
  );

  // Ring of recent magnitudes; read at the slot, written back on commit.
  ampd_ram #(
    .WIDTH (MAG_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (slot_q),
    .wdata_i (mag),
    .re_i    (state_q == S_SQR && axis_q == 2'd0),
    .raddr_i (slot_q),
    .rdata_o (ring_rdata)
  );

  // New running sum and divisor.
  assign warm = (k_q < IDX_W'(weff));

  always_comb begin
    if (k_q == '0) begin
      sum_d = SUM_W'(mag);
      div_d = DV_W'(1);
    end else if (warm) begin
      sum_d = sum_q + SUM_W'(mag);
      div_d = k_q[DV_W-1:0] + DV_W'(1);
    end else begin
      sum_d = sum_q + SUM_W'(mag) - SUM_W'(ring_rdata);
      div_d = weff;
    end
  end

  ampd_div #(
    .NUM_W (NUM_W),
    .DEN_W (DV_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_SUM),
    .num_i   ({sum_d, FRAC_W'(0)}),
    .den_i   (div_d),
    .quo_o   (quo),
    .sts_o   (dv_sts)
  );

  // Average saturated to 24 bits, slope and peak decision.
  assign mean       = (|quo[NUM_W-1:MEAN_W]) ? '1 : quo[MEAN_W-1:0];
  assign rising     = (k_q == '0) || (mean >= prev_mean_q);
  assign refr_limit = {1'b0, last_peak_q} + (IDX_W + 1)'(refr_q);
  assign peak       = prev_rising_q && !rising && (mean > thr_q)
                      && ({1'b0, k_q} > refr_limit);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept_in) state_d = S_SQR;
      S_SQR:  if (axis_q == 2'd2) state_d = S_ROOT;
      S_ROOT: if (sq_sts.done) state_d = S_SUM;
      S_SUM:  state_d = S_DIV;
      S_DIV:  if (dv_sts.done) state_d = S_DONE;
      S_DONE: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      axis_q        <= '0;
      sum_q         <= '0;
      pos_q         <= '0;
      prev_mean_q   <= '0;
      prev_rising_q <= 1'b1;
      last_peak_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SQR) begin
        axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
      end
      if (state_q == S_SUM) begin
        sum_q <= sum_d;
      end
      if (commit) begin
        pos_q         <= slot_next;
        prev_mean_q   <= mean;
        prev_rising_q <= rising;
        if (k_q == '0) begin
          last_peak_q <= '0;
        end else if (peak) begin
          last_peak_q <= k_q;
        end
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sample capture, square accumulation and result beat.
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      ax_q   <= accel_x_i[ACC_W-1] ? (~accel_x_i + ACC_W'(1)) : accel_x_i;
      ay_q   <= accel_y_i[ACC_W-1] ? (~accel_y_i + ACC_W'(1)) : accel_y_i;
      az_q   <= accel_z_i[ACC_W-1] ? (~accel_z_i + ACC_W'(1)) : accel_z_i;
      k_q    <= sample_index_i;
      slot_q <= slot_d;
      acc_q  <= '0;
    end else if (state_q == S_SQR) begin
      acc_q <= sq_total;
    end
    if (commit) begin
      peak_found_q <= peak;
      peak_value_q <= peak ? mean : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign peak_found_o = peak_found_q;
  assign peak_value_o = peak_value_q;

`ifndef SYNTHESIS
  // An accepted sample keeps the input stalled in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted sample");

  // A result beat without a peak carries a zero value.
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !peak_found_o) |-> (peak_value_o == '0))
    else $error("non-peak result with nonzero value");

  // The root finishes before the divider is started.
  a_unit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_sts.done |-> !dv_sts.busy)
    else $error("square root finished while divider busy");
`endif

endmodule
